FILE: design/lru_kv_pkg.sv
// Shared types and constants for the LRU key-value cache.
`default_nettype none

package lru_kv_pkg;

    // Store geometry
    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 16;

    // Fixed field widths of the channels
    localparam int KEY_W   = 16;
    localparam int VALUE_W = 16;
    localparam int CAP_W   = 5;

    // Derived widths
    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

    typedef enum logic [0:0] {
        FUNC_GET = 1'b0,
        FUNC_PUT = 1'b1
    } func_t;

    typedef struct packed {
        func_t              func;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } lru_kv_in_t;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] read_value;
        logic               evicted;
    } lru_kv_out_t;

endpackage

`default_nettype wire

FILE: design/lru_kv_store.sv
// Entry store of the LRU cache: key match, recency ranks and replacement.
`default_nettype none

module lru_kv_store (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [lru_kv_pkg::CAP_W-1:0]   capacity,
    input  wire logic                           fire,
    input  wire lru_kv_pkg::lru_kv_in_t         req,
    output lru_kv_pkg::lru_kv_out_t             rsp
);

    localparam int N = lru_kv_pkg::ENTRIES;

    logic [lru_kv_pkg::KEY_BITS-1:0]   key_reg   [N];
    logic [lru_kv_pkg::VALUE_BITS-1:0] value_reg [N];
    logic [lru_kv_pkg::RANK_W-1:0]     rank_reg  [N];
    logic [lru_kv_pkg::RANK_W-1:0]     rank_next [N];
    logic [N-1:0]                      valid_reg;
    logic [N-1:0]                      valid_next;
    logic [lru_kv_pkg::CNT_W-1:0]      count_reg;
    logic [lru_kv_pkg::CNT_W-1:0]      count_next;

    logic [lru_kv_pkg::KEY_BITS-1:0]   key_in;
    logic [lru_kv_pkg::VALUE_BITS-1:0] value_in;
    logic [N-1:0]                      match;
    logic [N-1:0]                      victim_oh;
    logic [N-1:0]                      free_vec;
    logic [N-1:0]                      free_oh;
    logic [N-1:0]                      slot_oh;
    logic                              found;
    logic                              is_put;
    logic                              room;
    logic                              do_insert;
    logic                              do_hit;
    logic [lru_kv_pkg::RANK_W-1:0]     hit_rank;
    logic [lru_kv_pkg::RANK_W-1:0]     lru_rank;
    logic [lru_kv_pkg::VALUE_BITS-1:0] hit_value;
    logic [lru_kv_pkg::CMP_W-1:0]      cap_eff;
    logic [lru_kv_pkg::CMP_W-1:0]      count_wide;

    assign key_in   = req.key[lru_kv_pkg::KEY_BITS-1:0];
    assign value_in = req.value[lru_kv_pkg::VALUE_BITS-1:0];
    assign is_put   = (req.func == lru_kv_pkg::FUNC_PUT);

    // Saturate capacity at the number of entries
    assign cap_eff = (lru_kv_pkg::CMP_W'(capacity) > lru_kv_pkg::CMP_W'(N))
                   ? lru_kv_pkg::CMP_W'(N) : lru_kv_pkg::CMP_W'(capacity);
    assign count_wide = lru_kv_pkg::CMP_W'(count_reg);
    assign room       = count_wide < cap_eff;
    assign lru_rank   = lru_kv_pkg::RANK_W'(count_reg - 1'b1);

    // Lowest free slot
    assign free_vec = ~valid_reg;
    assign free_oh  = free_vec & (~free_vec + 1'b1);

    always_comb
    begin
        hit_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < N; i++)
        begin
            match[i]     = valid_reg[i] && (key_reg[i] == key_in);
            victim_oh[i] = valid_reg[i] && (rank_reg[i] == lru_rank);
            if (match[i])
            begin
                hit_rank  = hit_rank | rank_reg[i];
                hit_value = hit_value | value_reg[i];
            end
        end
    end

    assign found     = |match;
    assign do_hit    = fire && found;
    assign do_insert = fire && !found && is_put && (room || (count_reg != '0));
    assign slot_oh   = room ? free_oh : victim_oh;

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < N; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (do_hit)
            begin
                if (match[i])
                    rank_next[i] = '0;
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                    rank_next[i] = rank_reg[i] + 1'b1;
            end
            else if (do_insert)
            begin
                if (slot_oh[i])
                begin
                    rank_next[i]  = '0;
                    valid_next[i] = 1'b1;
                end
                else if (valid_reg[i])
                    rank_next[i] = rank_reg[i] + 1'b1;
            end
        end
        if (do_insert && room)
            count_next = count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < N; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < N; i++)
                rank_reg[i] <= rank_next[i];
        end
    end

    // Key and value payload: written on insert, value also on a put hit
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            if (do_insert && slot_oh[i])
            begin
                key_reg[i]   <= key_in;
                value_reg[i] <= value_in;
            end
            else if (do_hit && is_put && match[i])
                value_reg[i] <= value_in;
        end
    end

    always_comb
    begin
        rsp.hit        = found;
        rsp.read_value = (found && !is_put) ? lru_kv_pkg::VALUE_W'(hit_value) : '0;
        rsp.evicted    = !found && is_put && !room;
    end

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        lru_kv_pkg::CNT_W'($countones(valid_reg)) == count_reg)
        else $error("entry count differs from number of valid entries");

    a_key_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("key matches more than one entry");

    a_victim_found: assert property (@(posedge clk) disable iff (!rst_n)
        (do_insert && !room) |-> $onehot(victim_oh))
        else $error("no unique least recent entry at eviction");

    a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (do_insert && room) |-> (free_vec != '0))
        else $error("insert with room but no free entry");

endmodule

`default_nettype wire

FILE: design/lru_key_value_cache_top.sv
// Top level of the fully associative LRU key-value cache.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries get or put requests.
//   A transfer happens on a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall / out_item) returns exactly one
//   result per request, in request order: hit, read_value, evicted.
//   Config channel (cfg_valid / cfg_ready / cfg_data) writes the capacity;
//   cfg_ready is always high. Write it only while the cache is idle.
// Path: a request transferred on the input channel waits in the input
//   register, is processed from it into the result register, and out_valid
//   rises once the result register is loaded; a stall can hold it in between.
// Throughput: one request per cycle while out_stall is low; the key compare
//   across all entries and the rank update are done in one pass between the
//   input register and the result register, which bounds the rate.
// Reset (rst_n low, async): all entries invalid, ranks and count cleared,
//   capacity back to 16, both pipeline registers empty.
// Stall: while out_stall holds a full result register, the input register
//   holds its request and in_stall rises once it is occupied; nothing drops.
`default_nettype none

module lru_key_value_cache_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire lru_kv_pkg::lru_kv_in_t        in_item,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output lru_kv_pkg::lru_kv_out_t            out_item,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lru_kv_pkg::CAP_W-1:0]  cfg_data
);

    logic                              in_valid_reg;
    logic                              in_valid_next;
    lru_kv_pkg::lru_kv_in_t            in_item_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    lru_kv_pkg::lru_kv_out_t           out_item_reg;
    lru_kv_pkg::lru_kv_out_t           rsp;
    logic [lru_kv_pkg::CAP_W-1:0]      capacity_reg;
    logic                              accept;
    logic                              process;

    // Process the held request when the result register is free or draining
    assign process  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !process;
    assign accept   = in_valid && !in_stall;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (process)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (process)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            capacity_reg  <= lru_kv_pkg::CAPACITY_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                capacity_reg <= cfg_data;
        end
    end

    // Payload registers: load the request on transfer, the result on process
    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= in_item;
        if (process)
            out_item_reg <= rsp;
    end

    lru_kv_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .capacity (capacity_reg),
        .fire     (process),
        .req      (in_item_reg),
        .rsp      (rsp)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_hit_not_evicted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.hit && out_item.evicted))
        else $error("result flags both hit and eviction");

    a_read_value_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.read_value != '0)) |-> out_item.hit)
        else $error("nonzero read value without a hit");

    a_result_follows_process: assert property (@(posedge clk) disable iff (!rst_n)
        process |=> out_valid)
        else $error("processed request produced no result");

endmodule

`default_nettype wire
